/* rtl/vbe_pkg.sv */
// Shared types and constants for the display register file.
// No dependencies; imported by every module of the block.
package vbe_pkg;

   localparam int unsigned MAX_XRES = 2560;
   localparam int unsigned MAX_YRES = 1600;
   localparam int unsigned MAX_BPP  = 32;

   localparam logic [15:0] IDX_ID      = 16'd0;
   localparam logic [15:0] IDX_XRES    = 16'd1;
   localparam logic [15:0] IDX_YRES    = 16'd2;
   localparam logic [15:0] IDX_BPP     = 16'd3;
   localparam logic [15:0] IDX_ENABLE  = 16'd4;
   localparam logic [15:0] IDX_BANK    = 16'd5;
   localparam logic [15:0] IDX_VWIDTH  = 16'd6;
   localparam logic [15:0] IDX_VHEIGHT = 16'd7;
   localparam logic [15:0] IDX_XOFF    = 16'd8;
   localparam logic [15:0] IDX_YOFF    = 16'd9;
   localparam logic [15:0] IDX_VRAM    = 16'd10;
   localparam logic [15:0] IDX_DDC     = 16'd11;

   localparam logic [15:0] ID_MIN      = 16'hB0C0;
   localparam logic [15:0] ID_MAX      = 16'hB0C5;
   localparam logic [15:0] DDC_VALUE   = 16'h000F;
   localparam logic [15:0] UNKNOWN_RD  = 16'hFFFF;

   localparam int unsigned EN_ENABLE = 0;
   localparam int unsigned EN_CAPS   = 1;
   localparam int unsigned EN_DAC8   = 5;
   localparam int unsigned EN_NOCLR  = 7;

   localparam logic [1:0] PAL_NONE  = 2'd0;
   localparam logic [1:0] PAL_TO8   = 2'd1;
   localparam logic [1:0] PAL_TO6   = 2'd2;

   localparam logic [2:0] ACT_WR_INDEX = 3'd0;
   localparam logic [2:0] ACT_RD_INDEX = 3'd1;
   localparam logic [2:0] ACT_WR_DATA  = 3'd2;
   localparam logic [2:0] ACT_RD_DATA  = 3'd3;
   localparam logic [2:0] ACT_LATCH    = 3'd4;

   typedef enum logic [2:0] {
      OP_WR_INDEX, OP_RD_INDEX, OP_WR_DATA, OP_RD_DATA, OP_LATCH, OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] value;
   } item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        write_rejected;
      logic        mode_changed;
      logic        clear_vram;
      logic [1:0]  palette_change;
      logic [2:0]  pixel_format;
      logic [17:0] line_pitch;
      logic [24:0] frame_base;
      logic [2:0]  pan_pixels;
      logic        frame_valid;
   } rsp_type;

   function automatic logic [2:0] fmt_of(input logic en, input logic [5:0] depth);
      logic [2:0] f;
      if (!en || depth <= 6'd4)  f = 3'd0;
      else if (depth <= 6'd8)    f = 3'd1;
      else if (depth <= 6'd15)   f = 3'd2;
      else if (depth <= 6'd16)   f = 3'd3;
      else if (depth <= 6'd24)   f = 3'd4;
      else                       f = 3'd5;
      return f;
   endfunction

   function automatic logic depth_ok(input logic [15:0] v);
      return v == 16'd4 || v == 16'd8 || v == 16'd15 || v == 16'd16 ||
             v == 16'd24 || v == 16'd32;
   endfunction

endpackage

/* rtl/vbe_front.sv */
// Front end: accepts beats, classifies the action and queues them (2 deep).
// Depends on vbe_pkg.
module vbe_front import vbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_data_value,
   output logic        req_full,
   input  logic        deq,
   output logic        head_valid,
   output item_type    head
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       enq;
   item_type   item;

   always_comb begin
      unique case (req_action)
         ACT_WR_INDEX: item.op = OP_WR_INDEX;
         ACT_RD_INDEX: item.op = OP_RD_INDEX;
         ACT_WR_DATA:  item.op = OP_WR_DATA;
         ACT_RD_DATA:  item.op = OP_RD_DATA;
         ACT_LATCH:    item.op = OP_LATCH;
         default:      item.op = OP_NONE;
      endcase
      item.value = req_data_value;
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign enq        = req_push && !req_full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq;
      rd_ptr_in = rd_ptr_ff ^ deq;
      cnt_in    = cnt_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/vbe_back.sv */
// Back end: register file, frame latch sequencer and the result register.
// Depends on vbe_pkg.
module vbe_back import vbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head,
   output logic        deq,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM} state_type;

   state_type   state_ff, state_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] enable_ff, enable_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] bank_ff, bank_in;
   logic [15:0] xres_ff, xres_in;
   logic [15:0] yres_ff, yres_in;
   logic [5:0]  depth_ff, depth_in;
   logic [15:0] vw_ff, vw_in;
   logic [15:0] vh_ff, vh_in;
   logic [15:0] ox_ff, ox_in;
   logic [15:0] oy_ff, oy_in;
   logic [8:0]  banks_ff, banks_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [17:0] pitch_ff, pitch_in;
   logic [17:0] xterm_ff, xterm_in;
   logic [2:0]  pan_ff, pan_in;
   logic [33:0] pstart_ff, pstart_in;
   logic [33:0] pspan_ff, pspan_in;

   rsp_type     res;
   logic [15:0] v;
   logic [15:0] rd_mux;
   logic        caps;
   logic [2:0]  bytes;
   logic [34:0] start;
   logic [35:0] total;
   logic [24:0] size;
   logic        ok;

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;
   assign v         = head.value;
   assign caps      = enable_ff[EN_CAPS];
   assign bytes     = 3'((depth_ff + 6'd7) >> 3);
   assign size      = {banks_ff, 16'h0000};
   assign start     = {1'b0, pstart_ff} + {17'd0, xterm_ff};
   assign total     = {1'b0, start} + {2'b00, pspan_ff};
   assign ok        = total <= {11'd0, size};

   always_comb begin
      unique case (index_ff)
         IDX_ID:      rd_mux = id_ff;
         IDX_XRES:    rd_mux = caps ? 16'(MAX_XRES) : xres_ff;
         IDX_YRES:    rd_mux = caps ? 16'(MAX_YRES) : yres_ff;
         IDX_BPP:     rd_mux = caps ? 16'(MAX_BPP) : {10'd0, depth_ff};
         IDX_ENABLE:  rd_mux = enable_ff;
         IDX_BANK:    rd_mux = bank_ff;
         IDX_VWIDTH:  rd_mux = vw_ff;
         IDX_VHEIGHT: rd_mux = vh_ff;
         IDX_XOFF:    rd_mux = ox_ff;
         IDX_YOFF:    rd_mux = oy_ff;
         IDX_VRAM:    rd_mux = {7'd0, banks_ff};
         IDX_DDC:     rd_mux = DDC_VALUE;
         default:     rd_mux = UNKNOWN_RD;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      enable_in    = enable_ff;
      id_in        = id_ff;
      bank_in      = bank_ff;
      xres_in      = xres_ff;
      yres_in      = yres_ff;
      depth_in     = depth_ff;
      vw_in        = vw_ff;
      vh_in        = vh_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      banks_in     = csr_write_enable ? csr_write_data : banks_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      pitch_in     = pitch_ff;
      xterm_in     = xterm_ff;
      pan_in       = pan_ff;
      pstart_in    = pstart_ff;
      pspan_in     = pspan_ff;
      deq          = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && !out_valid_ff) begin
               deq = 1'b1;
               unique case (head.op)
                  OP_WR_INDEX: index_in = v;
                  OP_RD_INDEX: res.read_data = index_ff;
                  OP_RD_DATA:  res.read_data = rd_mux;
                  OP_WR_DATA: begin
                     unique case (index_ff)
                        IDX_ID: begin
                           if (v < ID_MIN || v > ID_MAX) res.write_rejected = 1'b1;
                           else id_in = v;
                        end
                        IDX_XRES: xres_in = v;
                        IDX_YRES: yres_in = v;
                        IDX_BPP: begin
                           if (!depth_ok(v)) begin
                              res.write_rejected = 1'b1;
                           end else begin
                              depth_in = v[5:0];
                              res.mode_changed = enable_ff[EN_ENABLE];
                           end
                        end
                        IDX_ENABLE: begin
                           enable_in = v;
                           if (enable_ff[EN_ENABLE] != v[EN_ENABLE]) begin
                              res.mode_changed = 1'b1;
                              if (v[EN_ENABLE]) begin
                                 vw_in = xres_ff;
                                 vh_in = yres_ff;
                                 ox_in = 16'd0;
                                 oy_in = 16'd0;
                                 res.clear_vram = !v[EN_NOCLR];
                              end
                           end
                           if (enable_ff[EN_DAC8] != v[EN_DAC8])
                              res.palette_change = v[EN_DAC8] ? PAL_TO8 : PAL_TO6;
                        end
                        IDX_BANK: begin
                           // bank must lie below the configured size
                           if ({1'b0, v} >= {8'd0, banks_ff}) res.write_rejected = 1'b1;
                           else bank_in = v;
                        end
                        IDX_VWIDTH:  vw_in = v;
                        IDX_VHEIGHT: vh_in = v;
                        IDX_XOFF:    ox_in = v;
                        IDX_YOFF:    oy_in = v;
                        default: ;
                     endcase
                  end
                  OP_LATCH: begin
                     if (enable_ff[EN_ENABLE]) begin
                        if (depth_ff < 6'd8) begin
                           // 4bpp: pitch in dwords, panning from offset bit 4
                           pitch_in = 18'(({1'b0, vw_ff} + 17'd7) >> 3);
                           xterm_in = 18'(ox_ff >> 3);
                           pan_in   = {2'b00, ox_ff[4]};
                        end else begin
                           pitch_in = 18'({2'b00, vw_ff} * {15'd0, bytes});
                           xterm_in = 18'({2'b00, ox_ff} * {15'd0, bytes});
                           pan_in   = 3'd0;
                        end
                        state_in = ST_MUL;
                     end
                  end
                  OP_NONE: ;
                  default: ;
               endcase
               res.pixel_format = fmt_of(enable_in[EN_ENABLE], depth_in);
               out_in = res;
               if (state_in == ST_IDLE) out_valid_in = 1'b1;
            end
         end
         ST_MUL: begin
            pstart_in = {18'd0, oy_ff} * {16'd0, pitch_ff};
            pspan_in  = {16'd0, pitch_ff} * {18'd0, yres_ff};
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            res.pixel_format  = fmt_of(enable_ff[EN_ENABLE], depth_ff);
            res.line_pitch    = pitch_ff;
            res.frame_base    = ok ? start[24:0] : size;
            res.pan_pixels    = pan_ff;
            res.frame_valid   = ok;
            out_in            = res;
            out_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      pitch_ff  <= pitch_in;
      xterm_ff  <= xterm_in;
      pan_ff    <= pan_in;
      pstart_ff <= pstart_in;
      pspan_ff  <= pspan_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= 16'd0;
         enable_ff    <= 16'd0;
         id_ff        <= ID_MIN;
         bank_ff      <= 16'd0;
         xres_ff      <= 16'd640;
         yres_ff      <= 16'd480;
         depth_ff     <= 6'd32;
         vw_ff        <= 16'd0;
         vh_ff        <= 16'd0;
         ox_ff        <= 16'd0;
         oy_ff        <= 16'd0;
         banks_ff     <= 9'd256;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         enable_ff    <= enable_in;
         id_ff        <= id_in;
         bank_ff      <= bank_in;
         xres_ff      <= xres_in;
         yres_ff      <= yres_in;
         depth_ff     <= depth_in;
         vw_ff        <= vw_in;
         vh_ff        <= vh_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         banks_ff     <= banks_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/vbe_display_register_file_core.sv */
// Top level: index/data display register file.
// Register accesses pass through the front queue and the result register; a frame
// latch runs through the pitch step, two parallel multiplies (ST_MUL) and the sum and
// range check (ST_SUM) in the back end. A new beat is taken only once the last result
// has been popped, and none during a latch. Front queue holds 2 beats.
// Synchronous active-high reset restores state and control registers to their defaults.
module vbe_display_register_file_core import vbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_data_value,
   output logic        req_full,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_read_data,
   output logic        rsp_write_rejected,
   output logic        rsp_mode_changed,
   output logic        rsp_clear_vram,
   output logic [1:0]  rsp_palette_change,
   output logic [2:0]  rsp_pixel_format,
   output logic [17:0] rsp_line_pitch,
   output logic [24:0] rsp_frame_base,
   output logic [2:0]  rsp_pan_pixels,
   output logic        rsp_frame_valid
);

   logic     head_valid;
   logic     deq;
   item_type head;
   rsp_type  rsp;

   vbe_front u_front (
      .clock, .reset, .req_push, .req_action, .req_data_value, .req_full,
      .deq, .head_valid, .head
   );

   vbe_back u_back (
      .clock, .reset, .head_valid, .head, .deq,
      .csr_write_enable, .csr_write_data, .rsp_empty, .rsp_pop, .rsp
   );

   assign rsp_read_data      = rsp.read_data;
   assign rsp_write_rejected = rsp.write_rejected;
   assign rsp_mode_changed   = rsp.mode_changed;
   assign rsp_clear_vram     = rsp.clear_vram;
   assign rsp_palette_change = rsp.palette_change;
   assign rsp_pixel_format   = rsp.pixel_format;
   assign rsp_line_pitch     = rsp.line_pitch;
   assign rsp_frame_base     = rsp.frame_base;
   assign rsp_pan_pixels     = rsp.pan_pixels;
   assign rsp_frame_valid    = rsp.frame_valid;

endmodule
